@@ hw/rtl/rrps_pkg.sv @@
// Package for the rounded rectangle pixel shader: widths, codes and helpers.
package rrps_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = 13;
    localparam int POS_W      = 12;
    localparam int ORG_W      = 14;
    localparam int RAD_W      = 12;
    localparam int ADDR_W     = 24;
    localparam int PIX_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    typedef logic [1:0] t_op;

    localparam t_op OP_FILL    = 2'd0;
    localparam t_op OP_OUTLINE = 2'd1;
    localparam t_op OP_BLEND   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_W    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_H    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd7;

    // Clamps a written dimension to the largest supported size.
    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] lim;
        lim = DIM_W'(MAX_DIM);
        return (v > lim) ? lim : v;
    endfunction

endpackage

@@ hw/rtl/rounded_rect_pixel_shader.sv @@
// Rounded rectangle pixel shader: clipping, corner test, blend and address pipeline.
// Each item passes the stage 1 and stage 2 registers and then the output registers.
// Throughput: one item per cycle; o_busy is always low and start may stay high.
// The corner distance multipliers and the row times pitch multiplier set the
// three stage split: select, multiply, then sum, compare and pick.
// Reset (synchronous, active low) clears the valid bits and loads the register
// defaults: 1024 x 768 screen, pitch 1024, empty rectangle, square corners.
module rounded_rect_pixel_shader
    import rrps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [1:0]            i_op,
    input  logic [POS_W-1:0]      i_col,
    input  logic [POS_W-1:0]      i_row,
    input  logic [PIX_W-1:0]      i_color,
    input  logic [PIX_W-1:0]      i_dst_pixel,
    output logic                  o_valid,
    output logic                  o_write_enable,
    output logic [ADDR_W-1:0]     o_address,
    output logic [PIX_W-1:0]      o_pixel_value
);

    // Configuration registers. Dimensions are stored already clamped.
    logic [DIM_W-1:0] r_fb_width, r_fb_height, r_pitch, r_rect_w, r_rect_h;
    logic signed [ORG_W-1:0] r_rect_x, r_rect_y;
    logic [RAD_W-1:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_width  <= DIM_W'(1024);
            r_fb_height <= DIM_W'(768);
            r_pitch     <= DIM_W'(1024);
            r_rect_x    <= '0;
            r_rect_y    <= '0;
            r_rect_w    <= '0;
            r_rect_h    <= '0;
            r_radius    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FB_WIDTH:  r_fb_width  <= sat_dim(i_cfg_data[DIM_W-1:0]);
                REG_FB_HEIGHT: r_fb_height <= sat_dim(i_cfg_data[DIM_W-1:0]);
                REG_PITCH:     r_pitch     <= sat_dim(i_cfg_data[DIM_W-1:0]);
                REG_RECT_X:    r_rect_x    <= $signed(i_cfg_data);
                REG_RECT_Y:    r_rect_y    <= $signed(i_cfg_data);
                REG_RECT_W:    r_rect_w    <= sat_dim(i_cfg_data[DIM_W-1:0]);
                REG_RECT_H:    r_rect_h    <= sat_dim(i_cfg_data[DIM_W-1:0]);
                REG_RADIUS:    r_radius    <= i_cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline never stalls, so an item is taken in every cycle that start is high.
    assign o_busy = 1'b0;
    logic accept;
    assign accept = i_start && !o_busy;

    // ---------------------------------------------------------------
    // Stage 1: screen position, clipping, corner region and distances.
    // ---------------------------------------------------------------
    logic signed [ORG_W:0]   n_sx, n_sy;
    logic                    n_ok, n_edge, n_hit;
    logic signed [ORG_W-1:0] n_wr, n_hr, n_jc, n_ic, n_dx, n_dy;
    logic [DIM_W-1:0]        n_lx, n_ty, n_cx, n_cy;
    logic                    n_left, n_top, n_right, n_bot;

    always_comb begin
        n_sx = $signed(r_rect_x) + $signed({3'b000, i_col});
        n_sy = $signed(r_rect_y) + $signed({3'b000, i_row});
        n_ok = ({1'b0, i_col} < r_rect_w) && ({1'b0, i_row} < r_rect_h)
            && !n_sx[ORG_W] && (n_sx < $signed({2'b00, r_fb_width}))
            && !n_sy[ORG_W] && (n_sy < $signed({2'b00, r_fb_height}));

        n_edge = (i_row == '0) || ({1'b0, i_row} == r_rect_h - 1'b1)
            || (i_col == '0) || ({1'b0, i_col} == r_rect_w - 1'b1);

        // Start of the right and bottom corner bands; negative when the
        // radius exceeds the rectangle.
        n_wr = $signed({1'b0, r_rect_w}) - $signed({2'b00, r_radius});
        n_hr = $signed({1'b0, r_rect_h}) - $signed({2'b00, r_radius});
        n_jc = $signed({2'b00, i_col});
        n_ic = $signed({2'b00, i_row});

        n_left  = i_col < r_radius;
        n_top   = i_row < r_radius;
        n_right = n_jc >= n_wr;
        n_bot   = n_ic >= n_hr;

        n_lx = {1'b0, r_radius} - {1'b0, i_col} - 1'b1;
        n_ty = {1'b0, r_radius} - {1'b0, i_row} - 1'b1;
        n_dx = n_jc - n_wr;
        n_dy = n_ic - n_hr;

        // Corners are tried top-left, top-right, bottom-left, bottom-right.
        n_hit = 1'b1;
        if (n_left && n_top) begin
            n_cx = n_lx;
            n_cy = n_ty;
        end else if (n_right && n_top) begin
            n_cx = n_dx[DIM_W-1:0];
            n_cy = n_ty;
        end else if (n_left && n_bot) begin
            n_cx = n_lx;
            n_cy = n_dy[DIM_W-1:0];
        end else if (n_right && n_bot) begin
            n_cx = n_dx[DIM_W-1:0];
            n_cy = n_dy[DIM_W-1:0];
        end else begin
            n_hit = 1'b0;
            n_cx  = '0;
            n_cy  = '0;
        end
    end

    logic             r_s1_valid, r_s1_ok, r_s1_edge, r_s1_hit;
    t_op              r_s1_op;
    logic [DIM_W-1:0] r_s1_cx, r_s1_cy;
    logic [POS_W-1:0] r_s1_sx, r_s1_sy;
    logic [PIX_W-1:0] r_s1_color, r_s1_dst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
        r_s1_ok    <= n_ok;
        r_s1_edge  <= n_edge;
        r_s1_hit   <= n_hit;
        r_s1_op    <= i_op;
        r_s1_cx    <= n_cx;
        r_s1_cy    <= n_cy;
        r_s1_sx    <= n_sx[POS_W-1:0];
        r_s1_sy    <= n_sy[POS_W-1:0];
        r_s1_color <= i_color;
        r_s1_dst   <= i_dst_pixel;
    end

    // ---------------------------------------------------------------
    // Stage 2: squared distances, squared radius, row base and blend terms.
    // ---------------------------------------------------------------
    logic [7:0] alpha, alpha_n;
    assign alpha   = r_s1_color[31:24];
    assign alpha_n = 8'd255 - alpha;

    logic                 r_s2_valid, r_s2_ok, r_s2_edge, r_s2_hit;
    t_op                  r_s2_op;
    logic [2*DIM_W-1:0]   r_s2_cx2, r_s2_cy2;
    logic [2*RAD_W-1:0]   r_s2_rr;
    logic [ADDR_W-1:0]    r_s2_base;
    logic [POS_W-1:0]     r_s2_sx;
    logic [PIX_W-1:0]     r_s2_color;
    logic [15:0]          r_s2_sa [3];
    logic [15:0]          r_s2_da [3];
    logic [POS_W+DIM_W-1:0] n_base;

    assign n_base = r_s1_sy * r_pitch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_ok    <= r_s1_ok;
        r_s2_edge  <= r_s1_edge;
        r_s2_hit   <= r_s1_hit;
        r_s2_op    <= r_s1_op;
        r_s2_cx2   <= r_s1_cx * r_s1_cx;
        r_s2_cy2   <= r_s1_cy * r_s1_cy;
        r_s2_rr    <= r_radius * r_radius;
        r_s2_base  <= n_base[ADDR_W-1:0];
        r_s2_sx    <= r_s1_sx;
        r_s2_color <= r_s1_color;
        for (int c = 0; c < 3; c++) begin
            r_s2_sa[c] <= r_s1_color[8*c +: 8] * alpha;
            r_s2_da[c] <= r_s1_dst[8*c +: 8] * alpha_n;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: corner compare, mode decision, address and blended value.
    // ---------------------------------------------------------------
    logic [2*DIM_W:0]  dist2;
    logic              clipped;
    logic              n_we;
    logic [PIX_W-1:0]  n_value;
    logic [16:0]       mix [3];

    always_comb begin
        dist2   = {1'b0, r_s2_cx2} + {1'b0, r_s2_cy2};
        clipped = r_s2_hit && (dist2 > (2*DIM_W+1)'(r_s2_rr));
        for (int c = 0; c < 3; c++) begin
            mix[c] = {1'b0, r_s2_sa[c]} + {1'b0, r_s2_da[c]};
        end
        n_we    = 1'b0;
        n_value = '0;
        case (r_s2_op)
            OP_FILL: begin
                n_we    = r_s2_ok && !clipped;
                n_value = r_s2_color;
            end
            OP_OUTLINE: begin
                n_we    = r_s2_ok && !clipped && r_s2_edge;
                n_value = r_s2_color;
            end
            OP_BLEND: begin
                n_we    = r_s2_ok;
                n_value = {8'h00, mix[2][15:8], mix[1][15:8], mix[0][15:8]};
            end
            default: begin
                n_we    = 1'b0;
                n_value = '0;
            end
        endcase
    end

    logic [ADDR_W-1:0] n_addr;
    assign n_addr = r_s2_base + ADDR_W'(r_s2_sx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid        <= 1'b0;
            o_write_enable <= 1'b0;
        end else begin
            o_valid        <= r_s2_valid;
            o_write_enable <= r_s2_valid && n_we;
        end
        // Address and value read as zero on a result that does not write.
        o_address     <= n_we ? n_addr : '0;
        o_pixel_value <= n_we ? n_value : '0;
    end

    // ---------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------
    a_s1_to_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |=> r_s2_valid)
        else $error("stage 2 lost an item");

    a_s2_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |=> o_valid)
        else $error("output stage lost an item");

    a_we_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_write_enable |-> o_valid)
        else $error("write enable without a result");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_write_enable) |-> (o_address == '0 && o_pixel_value == '0))
        else $error("non-writing result carries data");

    a_blend_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_op == OP_BLEND && r_s2_ok) |=>
            (o_write_enable && o_pixel_value[31:24] == 8'h00))
        else $error("blended pixel must write with zero alpha");

endmodule
